>>> hw/rtl/dsk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsk_pkg : shared types and constants of the disk register port
// Register codes, status bits and the configuration bundle used by the
// register file and the access controller.
// ----------------------------------------------------------------------------
package dsk_pkg;

  // bytes per block and width of the byte offset
  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned OFF_W       = 9;
  localparam int unsigned BLK_W       = 16;

  // access kind
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // device register codes
  localparam logic [3:0] REG_BLOCK_LO = 4'd0;
  localparam logic [3:0] REG_BLOCK_HI = 4'd1;
  localparam logic [3:0] REG_DATA     = 4'd2;
  localparam logic [3:0] REG_STATUS   = 4'd3;

  // configuration register codes (word index on the APB port)
  localparam logic [1:0] CFG_IMAGE_LOADED    = 2'd0;
  localparam logic [1:0] CFG_WRITE_PROTECTED = 2'd1;
  localparam logic [1:0] CFG_BLOCK_COUNT     = 2'd2;

  // read values
  localparam logic [7:0] BYTE_NONE       = 8'hFF;
  localparam logic [7:0] BYTE_ZERO       = 8'h00;
  localparam logic [7:0] STATUS_NO_IMAGE = 8'h80;
  localparam logic [7:0] STATUS_WPROT    = 8'h40;

  // configuration bundle from the register file
  typedef struct packed {
    logic       image_loaded;
    logic       write_protected;
    logic [7:0] block_count;
  } dsk_cfg_t;

endpackage : dsk_pkg
`default_nettype wire

>>> hw/rtl/dsk_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsk_cfg : APB configuration registers
// Holds image_loaded, write_protected and block_count; pready is tied high.
// ----------------------------------------------------------------------------
module dsk_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output dsk_pkg::dsk_cfg_t      cfg
);

  dsk_pkg::dsk_cfg_t cfg_r;
  logic              wr_en;
  logic [1:0]        word_idx;

  assign pready   = 1'b1;
  assign word_idx = paddr[3:2];
  assign wr_en    = psel & penable & pwrite & pready;
  assign cfg      = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (word_idx)
        dsk_pkg::CFG_IMAGE_LOADED:    cfg_r.image_loaded    <= pwdata[0];
        dsk_pkg::CFG_WRITE_PROTECTED: cfg_r.write_protected <= pwdata[0];
        dsk_pkg::CFG_BLOCK_COUNT:     cfg_r.block_count     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (word_idx)
      dsk_pkg::CFG_IMAGE_LOADED:    prdata = {31'd0, cfg_r.image_loaded};
      dsk_pkg::CFG_WRITE_PROTECTED: prdata = {31'd0, cfg_r.write_protected};
      dsk_pkg::CFG_BLOCK_COUNT:     prdata = {24'd0, cfg_r.block_count};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule : dsk_cfg
`default_nettype wire

>>> hw/rtl/dsk_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsk_store : image byte store
// Single-write, single-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module dsk_store #(
  parameter int unsigned AW    = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  assign rdata = rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule : dsk_store
`default_nettype wire

>>> hw/rtl/block_disk_register_port.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_disk_register_port : block storage device behind four byte registers
// Bus accesses arrive as stream transactions; one result per transaction.
// ----------------------------------------------------------------------------
// Each access yields exactly one result. Some data register accesses reach the
// byte store and pass through S_DATA: a read with an image loaded, or a write
// with an image loaded and no write protection, in either case inside the
// image. The byte store has a registered read port, so S_IDLE reads the
// addressed byte and S_DATA returns it (read) or compares it and writes the
// new byte back (write). All other accesses complete in S_IDLE. The result
// is registered and appears the cycle after the last cycle of its access. It
// waits in an output register; the next access is taken once that register
// is free or is being emptied, so a stalled result side holds off the access
// side. The store holds BLOCKS blocks of 512 bytes and needs no clearing
// pass; it must be filled through data writes before being read. any_dirty
// goes high on the first data write that changes a stored byte.
module block_disk_register_port #(
  parameter int unsigned BLOCKS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // access channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] write_data
  input  wire logic [4:0]  in_tuser,   // [0] op, [4:1] reg_index
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [7:0] read_data, [8] any_dirty, rest 0
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned DEPTH = BLOCKS * dsk_pkg::BLOCK_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned FULL_W = dsk_pkg::BLK_W + dsk_pkg::OFF_W;
  localparam logic [16:0] BLOCKS_LIM = 17'(BLOCKS);

  typedef enum logic {S_IDLE, S_DATA} state_t;

  dsk_pkg::dsk_cfg_t cfg;

  state_t                      state_r,    state_nxt;
  logic [dsk_pkg::BLK_W-1:0]   block_r,    block_nxt;
  logic [dsk_pkg::OFF_W-1:0]   offset_r,   offset_nxt;
  logic                        dirty_r,    dirty_nxt;
  logic                        out_vld_r,  out_vld_nxt;
  logic [7:0]                  out_rd_r,   out_rd_nxt;
  logic                        out_dirty_r, out_dirty_nxt;
  logic                        pend_wr_r,  pend_wr_nxt;
  logic [7:0]                  pend_wd_r,  pend_wd_nxt;
  logic [AW-1:0]               pend_addr_r, pend_addr_nxt;

  logic                        in_op;
  logic [3:0]                  in_reg;
  logic [7:0]                  in_wd;
  logic                        accept;
  logic [16:0]                 blk_lim;
  logic                        hit;
  logic [FULL_W-1:0]           addr_full;
  logic [AW-1:0]               addr;
  logic                        mem_re;
  logic                        mem_we;
  logic [7:0]                  mem_rdata;

  // configuration registers
  dsk_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // image store
  dsk_store #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pend_addr_r),
    .wdata (pend_wd_r),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  // channel unpacking
  assign in_op  = in_tuser[0];
  assign in_reg = in_tuser[4:1];
  assign in_wd  = in_tdata;

  assign in_tready  = (state_r == S_IDLE) && (!out_vld_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_dirty_r, out_rd_r};

  // image bounds: block count clamped to the store size
  assign blk_lim   = ({9'd0, cfg.block_count} > BLOCKS_LIM) ? BLOCKS_LIM
                                                            : {9'd0, cfg.block_count};
  assign hit       = ({1'b0, block_r} < blk_lim);
  assign addr_full = {block_r, offset_r};
  assign addr      = addr_full[AW-1:0];

  // write the new byte back; an unchanged byte is rewritten with its own value
  assign mem_we = (state_r == S_DATA) && pend_wr_r;

  // access sequencing
  always_comb begin
    logic data_ok;
    data_ok       = 1'b0;
    state_nxt     = state_r;
    block_nxt     = block_r;
    offset_nxt    = offset_r;
    dirty_nxt     = dirty_r;
    out_vld_nxt   = out_vld_r;
    out_rd_nxt    = out_rd_r;
    out_dirty_nxt = out_dirty_r;
    pend_wr_nxt   = pend_wr_r;
    pend_wd_nxt   = pend_wd_r;
    pend_addr_nxt = pend_addr_r;
    mem_re        = 1'b0;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_rd_nxt    = dsk_pkg::BYTE_ZERO;
          out_dirty_nxt = dirty_r;
          out_vld_nxt   = 1'b1;
          if (in_op == dsk_pkg::OP_WRITE) begin
            case (in_reg)
              dsk_pkg::REG_BLOCK_LO: begin
                block_nxt  = {block_r[15:8], in_wd};
                offset_nxt = '0;
              end
              dsk_pkg::REG_BLOCK_HI: begin
                block_nxt  = {in_wd, block_r[7:0]};
                offset_nxt = '0;
              end
              dsk_pkg::REG_DATA: begin
                data_ok = cfg.image_loaded && !cfg.write_protected;
                if (data_ok) begin
                  offset_nxt = offset_r + 1'b1;
                  if (hit) begin
                    // finish after the old byte is read back
                    mem_re        = 1'b1;
                    pend_wr_nxt   = 1'b1;
                    pend_wd_nxt   = in_wd;
                    pend_addr_nxt = addr;
                    out_vld_nxt   = 1'b0;
                    state_nxt     = S_DATA;
                  end
                end
              end
              default: ;
            endcase
          end else begin
            case (in_reg)
              dsk_pkg::REG_DATA: begin
                out_rd_nxt = dsk_pkg::BYTE_NONE;
                if (cfg.image_loaded) begin
                  offset_nxt = offset_r + 1'b1;
                  if (hit) begin
                    mem_re      = 1'b1;
                    pend_wr_nxt = 1'b0;
                    out_vld_nxt = 1'b0;
                    state_nxt   = S_DATA;
                  end
                end
              end
              dsk_pkg::REG_STATUS: begin
                out_rd_nxt = (cfg.image_loaded ? dsk_pkg::BYTE_ZERO : dsk_pkg::STATUS_NO_IMAGE)
                           | (cfg.write_protected ? dsk_pkg::STATUS_WPROT : dsk_pkg::BYTE_ZERO);
              end
              default: out_rd_nxt = dsk_pkg::BYTE_NONE;
            endcase
          end
        end
      end
      S_DATA: begin
        // store data is valid now; output register is known to be free
        out_vld_nxt = 1'b1;
        if (pend_wr_r) begin
          out_rd_nxt = dsk_pkg::BYTE_ZERO;
          if (mem_rdata != pend_wd_r) begin
            dirty_nxt = 1'b1;
          end
        end else begin
          out_rd_nxt = mem_rdata;
        end
        out_dirty_nxt = dirty_nxt;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      block_r     <= '0;
      offset_r    <= '0;
      dirty_r     <= 1'b0;
      out_vld_r   <= 1'b0;
      out_dirty_r <= 1'b0;
      pend_wr_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      block_r     <= block_nxt;
      offset_r    <= offset_nxt;
      dirty_r     <= dirty_nxt;
      out_vld_r   <= out_vld_nxt;
      out_dirty_r <= out_dirty_nxt;
      pend_wr_r   <= pend_wr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_rd_r    <= out_rd_nxt;
    pend_wd_r   <= pend_wd_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

endmodule : block_disk_register_port
`default_nettype wire
